### design/ipd_pkg.sv
// Shared types, character codes and helpers for the IPD frame parser.
`default_nettype none

package ipd_pkg;

  // Width of the length accumulator and the payload counter.
  localparam int LenW   = 16;
  localparam int MulW   = LenW + 4;
  localparam int BufW   = 16;
  localparam int IdxW   = 16;
  localparam int CmpW   = (LenW > BufW) ? LenW : BufW;
  localparam int PrefixLen = 5;

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharI     = 8'h49;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharFour  = 8'h34;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [1:0] {
    StNoMatch    = 2'd0,
    StIncomplete = 2'd1,
    StComplete   = 2'd2
  } status_e;

  // Packed, so the first field lands in the highest bits and the last field in the lowest.
  typedef struct packed {
    logic            saving_payload;
    logic [7:0]      store_byte;
    logic [IdxW-1:0] store_index;
    logic            store_valid;
    logic [15:0]     payload_length;
    logic [2:0]      connection_id;
    status_e         status;
  } result_t;

  localparam int ResW  = $bits(result_t);
  localparam int DataW = ((ResW + 7) / 8) * 8;

  // "+IPD," one character per position.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = CharPlus;
      3'd1:    ch = CharI;
      3'd2:    ch = CharP;
      3'd3:    ch = CharD;
      3'd4:    ch = CharComma;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### design/ipd_frame_parser.sv
// Top level: byte stream in, one parse result per byte out.
// The result of a byte is registered in the output stage. Throughput: one byte
//   per cycle while s_axis_tready_o is high; the parser state updates on every
//   accepted byte and a two-entry output stage absorbs a stalled consumer.
// Reset (rst_ni low, asynchronous): parser back to prefix matching, length,
//   id and counters zero, buffer_length zero, output stage empty.
`default_nettype none

module ipd_frame_parser import ipd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,

  // Configuration: buffer_length, written when cfg_we_i is high
  input  wire logic             cfg_we_i,
  input  wire logic [BufW-1:0]  cfg_wdata_i,

  // Received bytes
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,   // [7:0] rx_byte

  // Parse results
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // from bit 0: status[1:0], connection_id[4:2], payload_length[20:5],
  // store_valid[21], store_index[37:22], store_byte[45:38],
  // saving_payload[46], zero pad[47]
  output logic [DataW-1:0]      m_axis_tdata_o
);

  logic [BufW-1:0] buffer_length_q;
  logic            req;
  result_t         core_res;
  result_t         out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_length_q <= '0;
    end else if (cfg_we_i) begin
      buffer_length_q <= cfg_wdata_i;
    end
  end

  // A request is taken whenever the skid slot is free.
  assign req = s_axis_tvalid_i && s_axis_tready_o;

  ipd_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .byte_i          (s_axis_tdata_i),
    .buffer_length_i (buffer_length_q),
    .result_o        (core_res)
  );

  ipd_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (core_res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata_o = {(DataW - ResW)'(0), out_res};

endmodule

`default_nettype wire

### design/ipd_core.sv
// Parser state registers and the per-byte recognition logic.
`default_nettype none

module ipd_core import ipd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_i,        // byte accepted this cycle
  input  wire logic [7:0]      byte_i,
  input  wire logic [BufW-1:0] buffer_length_i,
  output result_t              result_o
);

  typedef enum logic [2:0] {
    PhPrefix  = 3'd0,
    PhId      = 3'd1,
    PhComma   = 3'd2,
    PhLen     = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [2:0]      pos_q, pos_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic [2:0]      cid_q, cid_d;

  status_e         st;
  logic [7:0]      diff;
  logic [MulW-1:0] prod;
  logic [LenW-1:0] cnt_inc;
  logic            st_valid;
  logic [IdxW-1:0] st_index;
  logic [7:0]      st_byte;

  assign diff    = byte_i - CharZero;
  assign prod    = (MulW'(len_q) << 3) + (MulW'(len_q) << 1) + MulW'(diff[3:0]);
  assign cnt_inc = cnt_q + LenW'(1);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    cid_d    = cid_q;
    st       = StNoMatch;
    st_valid = 1'b0;
    st_index = '0;
    st_byte  = '0;

    case (phase_q)
      PhPrefix: begin
        if (pos_q < 3'(PrefixLen) && byte_i == prefix_char(pos_q)) begin
          pos_d = pos_q + 3'd1;
          st    = StIncomplete;
          if (pos_d >= 3'(PrefixLen)) phase_d = PhId;
        end
      end
      PhId: begin
        if (byte_i inside {[CharZero:CharFour]}) begin
          cid_d   = diff[2:0];
          phase_d = PhComma;
          st      = StIncomplete;
        end
      end
      PhComma: begin
        if (byte_i == CharComma) begin
          phase_d = PhLen;
          len_d   = '0;
          st      = StIncomplete;
        end
      end
      PhLen: begin
        if (byte_i == CharColon && len_q != '0) begin
          phase_d = PhPayload;
          st      = StIncomplete;
        end else if (byte_i inside {[CharZero:CharNine]}) begin
          // saturating len*10 + digit
          len_d = (prod > MulW'(LenMax)) ? LenMax : prod[LenW-1:0];
          st    = StIncomplete;
        end
      end
      PhPayload: begin
        if (CmpW'(cnt_q) < CmpW'(buffer_length_i)) begin
          st_valid = 1'b1;
          st_index = IdxW'(cnt_q);
          st_byte  = byte_i;
        end
        cnt_d = cnt_inc;
        st    = (cnt_inc == len_q) ? StComplete : StIncomplete;
      end
      default: ;
    endcase

    if (st != StIncomplete) begin
      phase_d = PhPrefix;
      pos_d   = '0;
      cnt_d   = '0;
    end

    // mismatch: retry the same byte as the start of a new prefix
    if (st == StNoMatch && byte_i == prefix_char(3'd0)) begin
      pos_d = 3'd1;
      st    = StIncomplete;
    end
  end

  always_comb begin
    result_o.status         = st;
    result_o.connection_id  = cid_d;
    result_o.payload_length = 16'(len_d);
    result_o.store_valid    = st_valid;
    result_o.store_index    = st_index;
    result_o.store_byte     = st_byte;
    result_o.saving_payload = (st == StIncomplete) && (phase_d == PhPayload);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPrefix;
      pos_q   <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      cid_q   <= '0;
    end else if (req_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      cid_q   <= cid_d;
    end
  end

  // Stores happen only in the payload phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i && result_o.store_valid |-> phase_q == PhPayload)
    else $error("store outside payload phase");

  // Any phase past the prefix implies the full prefix was matched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhPrefix |-> pos_q == 3'(PrefixLen))
    else $error("prefix position out of step with phase");

  // Payload phase is entered only with a nonzero declared length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> len_q != '0)
    else $error("payload phase with zero length");

  // A completed frame leaves the parser cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i && result_o.status == StComplete |=> phase_q == PhPrefix && cnt_q == '0)
    else $error("parser not cleared after frame end");

endmodule

`default_nettype wire

### design/ipd_out_skid.sv
// Two-entry output register with skid slot for the result stream.
`default_nettype none

module ipd_out_skid import ipd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  result_t   in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output result_t   out_data_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_valid_i;
      end
    end else if (in_valid_i && in_ready_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_ready_i) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && in_ready_o) begin
      skid_q <= in_data_i;
    end
  end

  // The skid slot only fills behind a held main entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry without main entry");

endmodule

`default_nettype wire
